// ===== hdl/ccsc_pkg.sv =====
package ccsc_pkg;

	// round key store geometry: one row holds the keys of one cascade round
	localparam int ROUND_KEY_WORDS = 128;
	localparam int LANES = 8;
	localparam int RK_ROWS = ROUND_KEY_WORDS / LANES;
	localparam int ROW_AW = $clog2(RK_ROWS);
	localparam int ROW_W = LANES * 32;

	// config register map
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE_0 = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 4'd8;

	// cipher constants
	localparam logic [31:0] GOLDEN = 32'h9E3779B9;
	localparam logic [31:0] SIGMA_0 = 32'h61707865;
	localparam logic [31:0] SIGMA_1 = 32'h3320646e;
	localparam logic [31:0] SIGMA_2 = 32'h79622d32;
	localparam logic [31:0] SIGMA_3 = 32'h6b206574;
	localparam logic [7:0] BLEND_0 = 8'hF0;
	localparam logic [7:0] BLEND_1 = 8'hCC;
	localparam logic [7:0] BLEND_2 = 8'hAA;

	typedef enum logic [2:0] {
		KG_IDLE,
		KG_EXP_RUN,
		KG_EXP_WR0,
		KG_EXP_WR1,
		KG_CAS
	} kg_state_t;

	typedef logic [15:0][31:0] cc_state_t;
	typedef logic [LANES-1:0][31:0] lanes_t;

	// classified input word
	typedef struct packed {
		logic [63:0] payload;
		logic [3:0]  byte_count;
		logic        last;
		logic [7:0]  byte_mask;
	} item_t;

	// back end to keystream generator
	typedef struct packed {
		logic pop;
		logic msg_end;
		logic in_msg;
	} ctl_t;

	// head of keystream block queue
	typedef struct packed {
		logic             valid;
		logic [ROW_W-1:0] block;
	} ks_t;

endpackage

// ===== hdl/ccsc_if.sv =====
interface ccsc_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] payload;
	logic [3:0]  byte_count;
	logic        last;
	modport source (output valid, payload, byte_count, last, input ready);
	modport sink (input valid, payload, byte_count, last, output ready);
endinterface

interface ccsc_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] cipher_word;
	logic [3:0]  valid_bytes;
	logic        end_of_message;
	modport source (output valid, cipher_word, valid_bytes, end_of_message, input ready);
	modport sink (input valid, cipher_word, valid_bytes, end_of_message, output ready);
endinterface

interface ccsc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [ccsc_pkg::CFG_IDX_W-1:0] index;
	logic [63:0]                    wdata;
	modport source (output valid, index, wdata, input ready);
	modport sink (input valid, index, wdata, output ready);
endinterface

// ===== hdl/cascade_ctr_stream_cipher_top.sv =====
// An input word passes through the front word queue and the output word register once a keystream block is queued;
// the first word of a message waits for its block.
// Each 32-byte block (4 words) is generated by the cascade unit doing
// one round per cycle through the round-key memory; two blocks are generated ahead.
// Reset and any key change trigger key expansion of 8 blocks.
// Reset clears control state; the round-key memory is rewritten by expansion, not cleared.
module cascade_ctr_stream_cipher_top (
	input  logic        clk,
	input  logic        arst_n,
	ccsc_in_if.sink     in_ch,
	ccsc_out_if.source  out_ch,
	ccsc_cfg_if.sink    cfg
);

	ccsc_pkg::item_t head;
	ccsc_pkg::ks_t   ks;
	ccsc_pkg::ctl_t  ctl;
	logic            head_valid, pop;

	ccsc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	ccsc_ksgen u_ksgen (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.ctl    (ctl),
		.ks     (ks)
	);

	ccsc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.ks         (ks),
		.ctl        (ctl),
		.out_ch     (out_ch)
	);

endmodule

// ===== hdl/ccsc_ram.sv =====
module ccsc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/ccsc_front.sv =====
module ccsc_front (
	input  logic             clk,
	input  logic             arst_n,
	ccsc_in_if.sink          in_ch,
	input  logic             pop,
	output logic             head_valid,
	output ccsc_pkg::item_t  head
);

	ccsc_pkg::item_t fifo_q [2];
	ccsc_pkg::item_t entry;
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;

	// classify: byte mask from count, counts above 8 keep all bytes
	always_comb begin
		entry.payload = in_ch.payload;
		entry.byte_count = in_ch.byte_count;
		entry.last = in_ch.last;
		for (int i = 0; i < 8; i++) begin
			entry.byte_mask[i] = 4'(i) < in_ch.byte_count;
		end
	end

	assign in_ch.ready = cnt_q != 2'd2;
	assign push = in_ch.valid && in_ch.ready;
	assign head_valid = cnt_q != 2'd0;
	assign head = fifo_q[rd_ptr_q];

	// word queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= entry;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== hdl/ccsc_ksgen.sv =====
module ccsc_ksgen (
	input  logic            clk,
	input  logic            arst_n,
	ccsc_cfg_if.sink        cfg,
	input  ccsc_pkg::ctl_t  ctl,
	output ccsc_pkg::ks_t   ks
);

	localparam logic [4:0] HR_LAST = 5'd19;
	localparam logic [2:0] BLK_LAST = 3'd7;
	localparam logic [ccsc_pkg::ROW_AW-1:0] RND_LAST = '1;

	// rotate by 16/12/8/7
	function automatic logic [31:0] rotl_q(input logic [31:0] x, input logic [1:0] q);
		logic [31:0] y;
		unique case (q)
			2'd0: y = {x[15:0], x[31:16]};
			2'd1: y = {x[19:0], x[31:20]};
			2'd2: y = {x[23:0], x[31:24]};
			default: y = {x[24:0], x[31:25]};
		endcase
		return y;
	endfunction

	function automatic ccsc_pkg::cc_state_t init_state(input logic [3:0][63:0] k,
			input logic [2:0] b);
		ccsc_pkg::cc_state_t st;
		st = '0;
		st[0] = ccsc_pkg::SIGMA_0;
		st[1] = ccsc_pkg::SIGMA_1;
		st[2] = ccsc_pkg::SIGMA_2;
		st[3] = ccsc_pkg::SIGMA_3;
		for (int i = 0; i < 4; i++) begin
			st[4 + 2 * i] = k[i][31:0];
			st[5 + 2 * i] = k[i][63:32];
		end
		st[12] = {29'd0, b};
		return st;
	endfunction

	// one add/xor/rotate step of four quarter rounds in parallel
	function automatic ccsc_pkg::cc_state_t qstep(input ccsc_pkg::cc_state_t x,
			input logic diag, input logic [1:0] s);
		ccsc_pkg::cc_state_t y;
		logic [3:0] ia, ib, ic, id;
		logic [31:0] sum;
		y = x;
		for (int q = 0; q < 4; q++) begin
			ia = 4'(q);
			ib = {2'b01, 2'(q) + {1'b0, diag}};
			ic = {2'b10, 2'(q) + {diag, 1'b0}};
			id = {2'b11, 2'(q) + {diag, diag}};
			if (!s[0]) begin
				sum = x[ia] + x[ib];
				y[ia] = sum;
				y[id] = rotl_q(x[id] ^ sum, s);
			end else begin
				sum = x[ic] + x[id];
				y[ic] = sum;
				y[ib] = rotl_q(x[ib] ^ sum, s);
			end
		end
		return y;
	endfunction

	// one cascade round
	function automatic ccsc_pkg::lanes_t casc_round(input ccsc_pkg::lanes_t s,
			input ccsc_pkg::lanes_t k, input logic [ccsc_pkg::ROW_AW-1:0] rnd,
			input logic [1:0] sel);
		ccsc_pkg::lanes_t t, a, y;
		logic [2:0]  px;
		logic [7:0]  m;
		logic [31:0] c, b;
		c = ccsc_pkg::GOLDEN + 32'(rnd);
		unique case (sel)
			2'd0: begin px = 3'd4; m = ccsc_pkg::BLEND_0; end
			2'd1: begin px = 3'd2; m = ccsc_pkg::BLEND_1; end
			default: begin px = 3'd1; m = ccsc_pkg::BLEND_2; end
		endcase
		for (int i = 0; i < ccsc_pkg::LANES; i++) begin
			t[i] = (s[i] + k[i]) ^ c;
		end
		for (int i = 0; i < ccsc_pkg::LANES; i++) begin
			a[i] = t[i] + t[3'(i) ^ px];
			b = rotl_q(t[i] ^ a[i], rnd[1:0]);
			y[i] = m[i] ? b : a[i];
		end
		return y;
	endfunction

	ccsc_pkg::kg_state_t state_q, state_d;
	logic [3:0][63:0]    key_q, nonce_q;
	logic                keys_ready_q, reload_q;
	ccsc_pkg::cc_state_t x_q, init_cur;
	logic [4:0]          hr_q;
	logic [1:0]          step_q;
	logic [2:0]          blk_q;
	ccsc_pkg::lanes_t    s_q, s_next, rk_row, ff_row;
	logic [ccsc_pkg::ROW_AW-1:0] rnd_q, raddr, waddr;
	logic [1:0]          sel3_q;
	logic [ccsc_pkg::ROW_W-1:0] ctr_q, rdata;
	logic [ccsc_pkg::ROW_W-1:0] fifo_q [2];
	logic                wr_ptr_q, rd_ptr_q;
	logic [1:0]          cnt_q;
	logic key_wr, nonce_wr, flush;
	logic start_exp, start_cas, load_ctr, ram_we, push, half;

	// config decode; writes between messages restart the generator
	assign cfg.ready = 1'b1;
	assign key_wr = cfg.valid && (cfg.index < ccsc_pkg::REG_NONCE_0);
	assign nonce_wr = cfg.valid && !key_wr && (cfg.index < ccsc_pkg::REG_LIMIT);
	assign flush = ctl.msg_end || ((key_wr || nonce_wr) && !ctl.in_msg);

	// round key memory: one row per cascade round
	assign half = state_q == ccsc_pkg::KG_EXP_WR1;
	assign waddr = {blk_q, half};
	assign init_cur = init_state(key_q, blk_q);
	always_comb begin
		for (int j = 0; j < ccsc_pkg::LANES; j++) begin
			ff_row[j] = half ? x_q[j + 8] + init_cur[j + 8] : x_q[j] + init_cur[j];
		end
	end

	ccsc_ram #(.WIDTH(ccsc_pkg::ROW_W), .DEPTH(ccsc_pkg::RK_ROWS)) u_rk_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (ff_row),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rk_row = rdata;
	assign s_next = casc_round(s_q, rk_row, rnd_q, sel3_q);

	// sequencer
	always_comb begin
		state_d = state_q;
		start_exp = 1'b0;
		start_cas = 1'b0;
		load_ctr = 1'b0;
		ram_we = 1'b0;
		push = 1'b0;
		raddr = rnd_q + 1'b1;
		unique case (state_q)
			ccsc_pkg::KG_IDLE: begin
				raddr = '0;
				if (reload_q) begin
					load_ctr = 1'b1;
				end else if (!keys_ready_q && !ctl.in_msg) begin
					start_exp = 1'b1;
					state_d = ccsc_pkg::KG_EXP_RUN;
				end else if (cnt_q != 2'd2) begin
					start_cas = 1'b1;
					state_d = ccsc_pkg::KG_CAS;
				end
			end
			ccsc_pkg::KG_EXP_RUN: begin
				if (step_q == 2'd3 && hr_q == HR_LAST) state_d = ccsc_pkg::KG_EXP_WR0;
			end
			ccsc_pkg::KG_EXP_WR0: begin
				ram_we = 1'b1;
				state_d = ccsc_pkg::KG_EXP_WR1;
			end
			ccsc_pkg::KG_EXP_WR1: begin
				ram_we = 1'b1;
				state_d = (blk_q == BLK_LAST) ? ccsc_pkg::KG_IDLE : ccsc_pkg::KG_EXP_RUN;
			end
			ccsc_pkg::KG_CAS: begin
				if (rnd_q == RND_LAST) begin
					push = 1'b1;
					state_d = ccsc_pkg::KG_IDLE;
				end
			end
			default: state_d = ccsc_pkg::KG_IDLE;
		endcase
		if (flush) begin
			state_d = ccsc_pkg::KG_IDLE;
			start_exp = 1'b0;
			start_cas = 1'b0;
			load_ctr = 1'b0;
			push = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ccsc_pkg::KG_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			nonce_q <= '0;
			keys_ready_q <= 1'b0;
			reload_q <= 1'b1;
			hr_q <= '0;
			step_q <= '0;
			blk_q <= '0;
			rnd_q <= '0;
			sel3_q <= '0;
			ctr_q <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (key_wr) key_q[cfg.index[1:0]] <= cfg.wdata;
			if (nonce_wr) nonce_q[cfg.index[1:0]] <= cfg.wdata;

			if (key_wr) begin
				keys_ready_q <= 1'b0;
			end else if (state_q == ccsc_pkg::KG_EXP_WR1 && blk_q == BLK_LAST) begin
				keys_ready_q <= 1'b1;
			end

			if (flush) reload_q <= 1'b1;
			else if (load_ctr) reload_q <= 1'b0;

			// expansion counters
			if (start_exp) begin
				blk_q <= '0;
				hr_q <= '0;
				step_q <= '0;
			end else if (state_q == ccsc_pkg::KG_EXP_RUN) begin
				step_q <= step_q + 1'b1;
				if (step_q == 2'd3) hr_q <= hr_q + 1'b1;
			end else if (state_q == ccsc_pkg::KG_EXP_WR1) begin
				blk_q <= blk_q + 1'b1;
				hr_q <= '0;
			end

			// cascade round counters
			if (start_cas) begin
				rnd_q <= '0;
				sel3_q <= '0;
			end else if (state_q == ccsc_pkg::KG_CAS) begin
				rnd_q <= rnd_q + 1'b1;
				sel3_q <= (sel3_q == 2'd2) ? 2'd0 : sel3_q + 2'd1;
			end

			// block counter
			if (load_ctr) ctr_q <= nonce_q;
			else if (push) ctr_q <= ctr_q + 1'b1;

			// keystream block queue
			if (flush) begin
				wr_ptr_q <= 1'b0;
				rd_ptr_q <= 1'b0;
				cnt_q <= 2'd0;
			end else begin
				if (push) wr_ptr_q <= !wr_ptr_q;
				if (ctl.pop) rd_ptr_q <= !rd_ptr_q;
				cnt_q <= cnt_q + 2'(push) - 2'(ctl.pop);
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (start_exp) begin
			x_q <= init_state(key_q, 3'd0);
		end else if (state_q == ccsc_pkg::KG_EXP_RUN) begin
			x_q <= qstep(x_q, hr_q[0], step_q);
		end else if (state_q == ccsc_pkg::KG_EXP_WR1) begin
			x_q <= init_state(key_q, blk_q + 1'b1);
		end
		if (start_cas) begin
			s_q <= ctr_q;
		end else if (state_q == ccsc_pkg::KG_CAS) begin
			s_q <= s_next;
		end
		if (push) fifo_q[wr_ptr_q] <= s_next;
	end

	assign ks.valid = cnt_q != 2'd0;
	assign ks.block = fifo_q[rd_ptr_q];

endmodule

// ===== hdl/ccsc_back.sv =====
module ccsc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  ccsc_pkg::item_t head,
	output logic            pop,
	input  ccsc_pkg::ks_t   ks,
	output ccsc_pkg::ctl_t  ctl,
	ccsc_out_if.source      out_ch
);

	logic        out_valid_q, in_msg_q, fire;
	logic [1:0]  word_pos_q;
	logic [63:0] cipher_q, ks_word, keep;
	logic [3:0]  vbytes_q;
	logic        eom_q;

	assign fire = head_valid && ks.valid && (!out_valid_q || out_ch.ready);
	assign pop = fire;
	assign ks_word = ks.block[{word_pos_q, 6'd0} +: 64];

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			keep[8 * i +: 8] = {8{head.byte_mask[i]}};
		end
	end

	// a block leaves the queue after its fourth word or at message end
	assign ctl.pop = fire && (word_pos_q == 2'd3 || head.last);
	assign ctl.msg_end = fire && head.last;
	assign ctl.in_msg = in_msg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			in_msg_q <= 1'b0;
			word_pos_q <= 2'd0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
				in_msg_q <= !head.last;
				word_pos_q <= head.last ? 2'd0 : word_pos_q + 2'd1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (fire) begin
			cipher_q <= (head.payload ^ ks_word) & keep;
			vbytes_q <= head.byte_count;
			eom_q <= head.last;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.cipher_word = cipher_q;
	assign out_ch.valid_bytes = vbytes_q;
	assign out_ch.end_of_message = eom_q;

endmodule
